[rtl/core/ppp_pkg.sv]
// shared types, constants and helpers for the pinhole point projection block
package ppp_pkg;

	localparam int COEF_W      = 32;
	localparam int NUM_VIEW    = 12;
	localparam int NUM_LENS    = 9;
	localparam int ACC_W       = 66;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int S_DATA_W    = 136;
	localparam int M_DATA_W    = 72;

	typedef enum logic [0:0] {
		FUNC_LOAD    = 1'b0,
		FUNC_PROJECT = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_DEPTH = 2'd1,
		STATUS_SAT   = 2'd2
	} status_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t x;
		coef_t y;
		coef_t z;
	} point_t;

	// push side of the point queue
	typedef struct packed {
		logic   push;
		point_t pt;
	} qpush_t;

	// returns {clipped, value}
	function automatic logic [COEF_W:0] sat32(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7fff_ffff);
		lo = -ACC_W'(64'sh8000_0000);
		if (a > hi) begin
			sat32 = {1'b1, 32'h7fff_ffff};
		end else if (a < lo) begin
			sat32 = {1'b1, 32'h8000_0000};
		end else begin
			sat32 = {1'b0, a[COEF_W-1:0]};
		end
	endfunction

endpackage

[rtl/core/pinhole_point_projection_top.sv]
// top level of the pinhole point projection block
// pipeline: 4 matrix stages, 32 + FRAC_BITS divider stages and the output register,
//   fed from the point queue
// throughput: one word per cycle on both sides unless the queue is full or the receiver stalls; loads give no result
// the divider's one-bit-per-stage chain sets the latency, its pipelining keeps full rate
// reset: asynchronous, clears all coefficients to zero and empties the pipeline
module pinhole_point_projection_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// coef_index[4:0], coef_value[36:5], point_x[68:37], point_y[100:69],
	// point_z[132:101], zero fill
	input  logic [ppp_pkg::S_DATA_W-1:0]  s_tdata,
	// func: 0 load coefficient, 1 project point
	input  logic                          s_tuser,
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pixel_u[31:0], pixel_v[63:32], status[65:64], zero fill
	output logic [ppp_pkg::M_DATA_W-1:0]  m_tdata
);
	import ppp_pkg::*;

	// front end to queue
	qpush_t  qp;
	logic    q_full;
	// queue to back end
	logic    q_pop;
	logic    q_avail;
	point_t  q_head;
	// coefficient file: user writes only while no point is in flight; the block does not check
	coef_t   view [NUM_VIEW];
	coef_t   lens [NUM_LENS];

	// classifies words: loads go to the coefficient file, points to the queue
	ppp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.qp       (qp),
		.view     (view),
		.lens     (lens)
	);

	// small queue decouples input acceptance from output stalls
	ppp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qp     (qp),
		.full   (q_full),
		.pop    (q_pop),
		.avail  (q_avail),
		.head   (q_head)
	);

	// transform, intrinsics, divide and saturate
	ppp_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_avail  (q_avail),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.view     (view),
		.lens     (lens),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[rtl/core/ppp_front.sv]
// front end: takes input words, stores coefficient loads, queues points
module ppp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ppp_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                            s_tuser,
	input  logic                            q_full,
	output ppp_pkg::qpush_t                 qp,
	output ppp_pkg::coef_t                  view [ppp_pkg::NUM_VIEW],
	output ppp_pkg::coef_t                  lens [ppp_pkg::NUM_LENS]
);
	import ppp_pkg::*;

	logic       acc_w;
	logic [4:0] idx;
	coef_t      val;

	assign s_tready = !q_full;
	assign acc_w    = s_tvalid && s_tready;
	assign idx      = s_tdata[4:0];
	assign val      = s_tdata[36:5];

	assign qp.push = acc_w && (func_t'(s_tuser) == FUNC_PROJECT);
	assign qp.pt.x = s_tdata[68:37];
	assign qp.pt.y = s_tdata[100:69];
	assign qp.pt.z = s_tdata[132:101];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VIEW; i++) view[i] <= '0;
			for (int i = 0; i < NUM_LENS; i++) lens[i] <= '0;
		end else if (acc_w && (func_t'(s_tuser) == FUNC_LOAD)) begin
			// indices past the lens block are dropped
			for (int i = 0; i < NUM_VIEW; i++)
				if (idx == 5'(i)) view[i] <= val;
			for (int i = 0; i < NUM_LENS; i++)
				if (idx == 5'(i + NUM_VIEW)) lens[i] <= val;
		end
	end

endmodule

[rtl/core/ppp_queue.sv]
// short point queue between front end and projection pipeline
module ppp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  ppp_pkg::qpush_t  qp,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output ppp_pkg::point_t  head
);
	import ppp_pkg::*;

	point_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_pop;

	assign full   = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign avail  = cnt_q != '0;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && avail;

	always_ff @(posedge clk) begin
		if (qp.push) mem_q[wr_q] <= qp.pt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qp.push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(qp.push) - QCNT_W'(do_pop);
		end
	end

endmodule

[rtl/core/ppp_div.sv]
// pipelined restoring divider, one quotient bit per stage, two numerators share a divisor
module ppp_div #(
	parameter int DW    = 48,
	parameter int TAG_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DW-1:0]     in_nu,
	input  logic [DW-1:0]     in_nv,
	input  logic [31:0]       in_d,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [DW-1:0]     out_qu,
	output logic [DW-1:0]     out_qv,
	output logic [TAG_W-1:0]  out_tag
);
	logic              vld_q [DW+1];
	logic [DW-1:0]     nu_q  [DW+1];
	logic [DW-1:0]     nv_q  [DW+1];
	logic [32:0]       ru_q  [DW+1];
	logic [32:0]       rv_q  [DW+1];
	logic [31:0]       d_q   [DW+1];
	logic [TAG_W-1:0]  tag_q [DW+1];

	always_comb begin
		vld_q[0] = in_valid;
		nu_q[0]  = in_nu;
		nv_q[0]  = in_nv;
		ru_q[0]  = '0;
		rv_q[0]  = '0;
		d_q[0]   = in_d;
		tag_q[0] = in_tag;
	end

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [33:0] tu;
		logic [33:0] tv;
		logic        ge_u;
		logic        ge_v;
		assign tu   = {ru_q[k], nu_q[k][DW-1]};
		assign tv   = {rv_q[k], nv_q[k][DW-1]};
		assign ge_u = tu >= {2'b00, d_q[k]};
		assign ge_v = tv >= {2'b00, d_q[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		// numerator shifts out at the top, quotient shifts in at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				ru_q[k+1]  <= ge_u ? 33'(tu - {2'b00, d_q[k]}) : tu[32:0];
				rv_q[k+1]  <= ge_v ? 33'(tv - {2'b00, d_q[k]}) : tv[32:0];
				nu_q[k+1]  <= {nu_q[k][DW-2:0], ge_u};
				nv_q[k+1]  <= {nv_q[k][DW-2:0], ge_v};
				d_q[k+1]   <= d_q[k];
				tag_q[k+1] <= tag_q[k];
			end
		end
	end

	assign out_valid = vld_q[DW];
	assign out_qu    = nu_q[DW];
	assign out_qv    = nv_q[DW];
	assign out_tag   = tag_q[DW];

endmodule

[rtl/core/ppp_back.sv]
// projection pipeline: two matrix products, divide, saturate, output register
module ppp_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_avail,
	input  ppp_pkg::point_t               q_head,
	output logic                          q_pop,
	input  ppp_pkg::coef_t                view [ppp_pkg::NUM_VIEW],
	input  ppp_pkg::coef_t                lens [ppp_pkg::NUM_LENS],
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ppp_pkg::M_DATA_W-1:0]  m_tdata
);
	import ppp_pkg::*;

	localparam int DW = 32 + FRAC_BITS;

	logic                 en;
	coef_t                p [3];

	logic                 v_s1;
	logic signed [63:0]   m_s1 [9];
	logic                 v_s2;
	coef_t                pc_s2 [3];
	logic                 sat_s2;
	logic                 v_s3;
	logic signed [63:0]   m_s3 [9];
	logic                 sat_s3;
	logic                 v_s4;
	coef_t                uc_s4 [3];
	logic                 sat_s4;

	logic [DW-1:0]        nu;
	logic [DW-1:0]        nv;
	logic [31:0]          den;
	logic [3:0]           tag;

	logic                 dv;
	logic [DW-1:0]        qu;
	logic [DW-1:0]        qv;
	logic [3:0]           dtag;

	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_data_q;

	// whole pipeline moves together, stalled only by the output register
	assign en    = !out_valid_q || m_tready;
	assign q_pop = en;

	assign p[0] = q_head.x;
	assign p[1] = q_head.y;
	assign p[2] = q_head.z;

	function automatic logic signed [ACC_W-1:0] fl(input logic signed [63:0] m);
		logic signed [63:0] s;
		s  = m >>> FRAC_BITS;
		fl = ACC_W'(s);
	endfunction

	function automatic logic [31:0] mag(input coef_t a);
		mag = a[31] ? 32'(-a) : 32'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0] acc;
		logic [COEF_W:0]         r;
		logic                    sf;
		if (en) begin
			// camera transform products
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < 3; c++)
					m_s1[i*3+c] <= view[i*4+c] * p[c];
			// camera point, translation added as is
			sf = 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc = ACC_W'(view[i*4+3]) + fl(m_s1[i*3]) + fl(m_s1[i*3+1])
					+ fl(m_s1[i*3+2]);
				r = sat32(acc);
				pc_s2[i] <= r[COEF_W-1:0];
				sf = sf | r[COEF_W];
			end
			sat_s2 <= sf;
			// intrinsic products
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < 3; c++)
					m_s3[i*3+c] <= lens[i*3+c] * pc_s2[c];
			sat_s3 <= sat_s2;
			// image point
			sf = sat_s3;
			for (int i = 0; i < 3; i++) begin
				acc = fl(m_s3[i*3]) + fl(m_s3[i*3+1]) + fl(m_s3[i*3+2]);
				r = sat32(acc);
				uc_s4[i] <= r[COEF_W-1:0];
				sf = sf | r[COEF_W];
			end
			sat_s4 <= sf;
		end
	end

	// magnitudes into the divider, signs and flags ride along as the tag
	assign nu  = {mag(uc_s4[0]), {FRAC_BITS{1'b0}}};
	assign nv  = {mag(uc_s4[1]), {FRAC_BITS{1'b0}}};
	assign den = mag(uc_s4[2]);
	assign tag = {sat_s4, uc_s4[2] == '0, uc_s4[0][31] ^ uc_s4[2][31],
		uc_s4[1][31] ^ uc_s4[2][31]};

	ppp_div #(
		.DW    (DW),
		.TAG_W (4)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_nu     (nu),
		.in_nv     (nv),
		.in_d      (den),
		.in_tag    (tag),
		.out_valid (dv),
		.out_qu    (qu),
		.out_qv    (qv),
		.out_tag   (dtag)
	);

	function automatic logic [COEF_W:0] fin(input logic [DW-1:0] q, input logic neg);
		logic [DW-1:0] lim;
		lim = DW'(33'h1_0000_0000) >> 1;
		if (neg) begin
			if (q > lim) fin = {1'b1, 32'h8000_0000};
			else         fin = {1'b0, 32'(-q[31:0])};
		end else begin
			if (q >= lim) fin = {1'b1, 32'h7fff_ffff};
			else          fin = {1'b0, q[31:0]};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		logic [COEF_W:0] ru;
		logic [COEF_W:0] rv;
		status_t         st;
		if (en) begin
			ru = fin(qu, dtag[1]);
			rv = fin(qv, dtag[0]);
			if (dtag[2]) begin
				out_data_q <= {6'b0, STATUS_DEPTH, 64'b0};
			end else begin
				st = (dtag[3] || ru[COEF_W] || rv[COEF_W]) ? STATUS_SAT : STATUS_OK;
				out_data_q <= {6'b0, st, rv[COEF_W-1:0], ru[COEF_W-1:0]};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[test/pinhole_point_projection_checker.sv]
// checker for the pinhole point projection block: predicts pixel words and compares them
`timescale 1ns / 100ps
module pinhole_point_projection_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [ppp_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                         s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [ppp_pkg::M_DATA_W-1:0] m_tdata,
	output int                           fail_count,
	output int                           pending
);
	import ppp_pkg::*;

	typedef struct packed {
		logic [31:0] u;
		logic [31:0] v;
		status_t     st;
	} pixel_t;

	logic signed [31:0] view_m [NUM_VIEW];
	logic signed [31:0] lens_m [NUM_LENS];
	pixel_t pixel_q [$];

	function automatic longint clip32(input longint a, inout bit clipped);
		if (a > 64'sd2147483647) begin
			clipped = 1;
			return 64'sd2147483647;
		end
		if (a < -64'sd2147483648) begin
			clipped = 1;
			return -64'sd2147483648;
		end
		return a;
	endfunction

	// product of two fixed-point values, floored
	function automatic longint fmul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> FRAC_BITS;
	endfunction

	function automatic pixel_t project_point(input longint px, input longint py,
			input longint pz);
		longint p [3];
		longint pc [3];
		longint uc [3];
		longint acc;
		bit clipped;
		pixel_t r;
		clipped = 0;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (int i = 0; i < 3; i++) begin
			acc = longint'(view_m[i*4+3]);
			for (int j = 0; j < 3; j++) acc += fmul(longint'(view_m[i*4+j]), p[j]);
			pc[i] = clip32(acc, clipped);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += fmul(longint'(lens_m[i*3+j]), pc[j]);
			uc[i] = clip32(acc, clipped);
		end
		if (uc[2] == 0) begin
			r.u = '0;
			r.v = '0;
			r.st = STATUS_DEPTH;
		end else begin
			// quotient truncates toward zero
			r.u = 32'(clip32((uc[0] * (64'sd1 << FRAC_BITS)) / uc[2], clipped));
			r.v = 32'(clip32((uc[1] * (64'sd1 << FRAC_BITS)) / uc[2], clipped));
			r.st = clipped ? STATUS_SAT : STATUS_OK;
		end
		return r;
	endfunction

	assign pending = pixel_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		logic [4:0] idx;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < NUM_VIEW; i++) view_m[i] <= '0;
			for (int i = 0; i < NUM_LENS; i++) lens_m[i] <= '0;
			pixel_q = {};
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$error("pixel word with nothing expected: %h", m_tdata);
					errs++;
				end else begin
					want = pixel_q.pop_front();
					if (m_tdata[31:0] !== want.u) begin
						$error("pixel_u expected %h actual %h", want.u, m_tdata[31:0]);
						errs++;
					end
					if (m_tdata[63:32] !== want.v) begin
						$error("pixel_v expected %h actual %h", want.v, m_tdata[63:32]);
						errs++;
					end
					if (m_tdata[65:64] !== want.st) begin
						$error("status expected %0d actual %0d", want.st, m_tdata[65:64]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				idx = s_tdata[4:0];
				if (func_t'(s_tuser) == FUNC_LOAD) begin
					if (idx < NUM_VIEW) view_m[idx] <= s_tdata[36:5];
					else if (idx < NUM_VIEW + NUM_LENS) lens_m[idx-NUM_VIEW] <= s_tdata[36:5];
				end else begin
					want = project_point(
						longint'($signed(s_tdata[68:37])),
						longint'($signed(s_tdata[100:69])),
						longint'($signed(s_tdata[132:101])));
					pixel_q = {pixel_q, want};
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

[test/pinhole_point_projection_top_tb.sv]
// testbench top for the pinhole point projection block: stimulus and verdict
`timescale 1ns / 100ps
module pinhole_point_projection_top_tb;
	import ppp_pkg::*;

	localparam int LATENCY = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [M_DATA_W-1:0] m_tdata;
	int fail_count;
	int pending;
	int cycles = 0;
	bit hold_off = 0;
	bit no_gaps = 0;

	always #5 clk = ~clk;

	pinhole_point_projection_top dut (.*);

	pinhole_point_projection_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .fail_count, .pending
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pinhole_point_projection_top_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls per word, plus one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(3) == 0 ? 0 : $urandom_range(17);
			if (gap != 0 || hold_off) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// long hold-off on the receiver while the sender streams, counted in cycles here
	initial begin
		@(posedge arst_n);
		wait (no_gaps);
		@(posedge clk);
		hold_off <= 1;
		repeat (400) @(posedge clk);
		hold_off <= 0;
	end

	// send one word; waits for the handshake
	task automatic send_word(input func_t f, input logic [4:0] idx,
			input logic [31:0] val, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(17);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= f;
		s_tdata <= {3'b0, z, y, x, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic load_coef(input logic [4:0] idx, input logic [31:0] val);
		send_word(FUNC_LOAD, idx, val, $urandom, $urandom, $urandom);
	endtask

	task automatic project(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		send_word(FUNC_PROJECT, 5'($urandom), $urandom, x, y, z);
	endtask

	// drain before any coefficient change
	task automatic settle;
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(65535 * 64)) - 32 * 65536 * 64);
			2: return 32'($signed($urandom_range(2 * 65536 * 20)) - 65536 * 20);
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	// one camera setup; kind 0 identity-like, 1 random moderate, 2 full random, 3 extremes
	task automatic load_camera(input int kind);
		logic [31:0] val;
		for (int i = 0; i < NUM_VIEW + NUM_LENS; i++) begin
			case (kind)
				0: val = (i == 0 || i == 5 || i == 10 || i == 12 || i == 16 || i == 20)
					? 32'h0001_0000 : (i == 11 ? 32'h000a_0000 : 32'h0);
				1: val = 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
				2: val = $urandom;
				default: val = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			endcase
			if (i >= 12 && kind == 1 && (i == 12 || i == 16))
				val = 32'($urandom_range(800 * 65536));
			load_coef(i[4:0], val);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// all-zero state: depth zero
		project(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		settle();
		load_camera(0);
		// out-of-range indices are ignored
		load_coef(5'd21, 32'h7fffffff);
		load_coef(5'd31, 32'h80000000);
		project(32'h0001_0000, 32'h0002_0000, 32'h0);
		project(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		project(32'h80000000, 32'h7fffffff, 32'h80000000);
		project(32'h0, 32'h0, 32'hfff6_0000); // depth zero through the camera
		project(32'hffffffff, 32'h1, 32'h0001_0000);
		project(32'h0, 32'h0, 32'h0);
		settle();
		load_camera(3);
		for (int i = 0; i < 5; i++) project(rnd_coord(3), rnd_coord(3), rnd_coord(3));
		settle();

		for (int ph = 0; ph < 16; ph++) begin
			load_camera(ph % 4 == 3 ? 2 : (ph % 4 == 0 ? 0 : 1));
			no_gaps = (ph % 5 == 2);
			for (int n = 0; n < 80; n++) begin
				int mode;
				mode = $urandom_range(9) < 6 ? 2 : $urandom_range(3);
				if ($urandom_range(19) == 0)
					load_coef(5'(21 + $urandom_range(10)), $urandom);
				else
					project(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
			end
			settle();
		end

		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("pinhole_point_projection_top_tb OK");
		end else begin
			$display("pinhole_point_projection_top_tb NOT OK");
		end
		$finish;
	end
endmodule

[files.f]
rtl/core/ppp_pkg.sv
rtl/core/ppp_front.sv
rtl/core/ppp_queue.sv
rtl/core/ppp_div.sv
rtl/core/ppp_back.sv
rtl/core/pinhole_point_projection_top.sv
test/pinhole_point_projection_checker.sv
test/pinhole_point_projection_top_tb.sv
